@@ src/bave_pkg.sv @@
// ----------------------------------------------------------------------------
// Barometric altitude estimator package
// Shared types, constants and the altitude lookup table built at elaboration.
// ----------------------------------------------------------------------------
package bave_pkg;

    localparam int ALT_TABLE_SIZE = 256;
    localparam int MAX_BATCH      = 1024;

    localparam int PRESS_W  = 17;
    localparam int ALT_W    = 24;
    localparam int SPEED_W  = 32;
    localparam int MS_W     = 32;
    localparam int TIME_W   = 64;
    localparam int PERIOD_W = 32;
    localparam int DIV_W    = 64;
    localparam int IDX_W    = (MAX_BATCH > 1) ? $clog2(MAX_BATCH) : 1;
    localparam int TAB_AW   = $clog2(ALT_TABLE_SIZE) + 1;
    localparam int POS_W    = PRESS_W + TAB_AW;

    localparam logic [PRESS_W-1:0]  SEA_LEVEL_PA     = 17'd101325;
    localparam logic [PERIOD_W-1:0] DEFAULT_PERIOD   = 32'd1000;
    localparam logic [19:0]         US_PER_S         = 20'd1000000;
    localparam logic                OP_SAMPLE        = 1'b0;
    localparam logic                OP_LIFTOFF       = 1'b1;

    // Reciprocal of 125 scaled by 2^68 and rounded up: for any 64-bit time t,
    // ((t >> 3) * MS_RECIP) >> 68 equals t / 1000 exactly.
    localparam logic [63:0]         MS_RECIP         = 64'd2361183241434822607;

    // Denominator of the Q30 pressure ratio at each table node.
    localparam logic [63:0]         TAB_RATIO_DEN    = 64'(ALT_TABLE_SIZE) * 64'd101325;

    typedef logic signed [ALT_W-1:0] alt_tab_t [0:ALT_TABLE_SIZE];

    typedef struct packed {
        logic                operation;
        logic [PRESS_W-1:0]  baro_pa;
        logic [TIME_W-1:0]   batch_start_us;
        logic [PERIOD_W-1:0] sample_period_us;
        logic                last_in_batch;
        logic [MS_W-1:0]     liftoff_time_ms;
    } sample_t;

    typedef struct packed {
        logic signed [ALT_W-1:0]   altitude_cm;
        logic                      altitude_ok;
        logic signed [SPEED_W-1:0] vertical_speed_cms;
        logic                      speed_ok;
        logic [MS_W-1:0]           update_time_ms;
    } result_t;

    // Builds the altitude node table in Q30 fixed point: log2 by repeated
    // squaring, scale by the exponent, then 2^e from square-root constants.
    function automatic alt_tab_t build_alt_table();
        alt_tab_t    tab;
        logic [63:0] ec [0:30];
        logic [63:0] v;
        logic [63:0] r;
        logic [63:0] b;
        logic [63:0] m;
        logic [63:0] y;
        logic [63:0] eb;
        logic [63:0] fp;
        logic [63:0] kk;
        longint      n;
        longint      lg;
        longint      e;
        longint      ip;
        ec[0] = 64'd1 << 31;
        for (int i = 1; i <= 30; i++) begin
            v = ec[i-1] << 30;
            r = 64'd0;
            b = 64'd1 << 62;
            for (int j = 0; j < 32; j++) begin
                if (v >= r + b) begin
                    v = v - (r + b);
                    r = (r >> 1) + b;
                end
                else begin
                    r = r >> 1;
                end
                b = b >> 2;
            end
            ec[i] = r;
        end
        for (int k = 0; k <= ALT_TABLE_SIZE; k++) begin
            if (k == 0) begin
                tab[k] = 24'sd4433000;
            end
            else begin
                kk = 64'(k);
                m  = ((kk * 64'd131072) << 30) / TAB_RATIO_DEN;
                n  = 0;
                for (int j = 0; j < 64; j++) begin
                    if (m < (64'd1 << 30)) begin
                        m = m << 1;
                        n = n - 1;
                    end
                end
                for (int j = 0; j < 64; j++) begin
                    if (m >= (64'd1 << 31)) begin
                        m = m >> 1;
                        n = n + 1;
                    end
                end
                lg = n * (longint'(1) << 30);
                for (int i = 1; i <= 30; i++) begin
                    m = (m * m) >> 30;
                    if (m >= (64'd1 << 31)) begin
                        m  = m >> 1;
                        lg = lg + (longint'(1) << (30 - i));
                    end
                end
                e  = lg * 1903 / 10000;
                eb = 64'(e + 64 * (longint'(1) << 30));
                ip = longint'(eb >> 30) - 64;
                fp = eb & ((64'd1 << 30) - 64'd1);
                y  = 64'd1 << 30;
                for (int i = 1; i <= 30; i++) begin
                    if (fp[30-i]) begin
                        y = (y * ec[i]) >> 30;
                    end
                end
                if (ip < 0) begin
                    y = (ip <= -63) ? 64'd0 : (y >> (-ip));
                end
                else if (ip > 0) begin
                    y = (ip >= 2) ? (y << 2) : (y << 1);
                end
                tab[k] = ALT_W'(64'd4433000 - ((64'd4433000 * y + (64'd1 << 29)) >> 30));
            end
        end
        return tab;
    endfunction

    localparam alt_tab_t ALT_TABLE = build_alt_table();

endpackage

@@ src/bave_div.sv @@
// ----------------------------------------------------------------------------
// Unsigned divider
// Restoring radix-2 divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module bave_div
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [bave_pkg::DIV_W-1:0] dividend,
    input  logic [bave_pkg::DIV_W-1:0] divisor,
    output logic                       done,
    output logic [bave_pkg::DIV_W-1:0] quotient
);
    import bave_pkg::*;

    localparam int CNT_W = $clog2(DIV_W);

    logic             busy_reg;
    logic             done_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [DIV_W-1:0] rem_reg;
    logic [DIV_W-1:0] quo_reg;
    logic [DIV_W-1:0] dsr_reg;
    logic [DIV_W:0]   trial;
    logic             ge;
    logic [DIV_W-1:0] rem_next;

    // One trial subtraction per cycle.
    always_comb
    begin
        trial    = {rem_reg, quo_reg[DIV_W-1]};
        ge       = (trial >= {1'b0, dsr_reg});
        rem_next = ge ? DIV_W'(trial - {1'b0, dsr_reg}) : trial[DIV_W-1:0];
    end

    // Iteration control.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg) begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(DIV_W - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        if (start) begin
            rem_reg <= '0;
            quo_reg <= dividend;
            dsr_reg <= divisor;
        end
        else if (busy_reg) begin
            rem_reg <= rem_next;
            quo_reg <= {quo_reg[DIV_W-2:0], ge};
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

@@ src/baro_altitude_velocity_estimator.sv @@
// ----------------------------------------------------------------------------
// Barometric altitude and vertical speed estimator
// Table-based altitude with finite-difference speed from batched samples.
// ----------------------------------------------------------------------------
// Input channel: sample_valid / sample_stall carry one sample_t beat, either a
// pressure sample or a liftoff event. Output channel: result_valid /
// result_stall carry one result_t beat at the last sample of each batch.
// A liftoff event is taken while the block is idle, and the block stays
// ready. A pressure sample holds sample_stall high through the table
// lookup, the altitude step, the speed check and the estimator update; a
// speed quotient runs before the update on the 64-bit radix-2 divider, one
// quotient bit per cycle. The last sample of a batch then forms the
// millisecond stamp, a reciprocal multiplication on one 32x32 multiplier,
// applies the liftoff clamp and loads the result register.
// The result register holds a finished beat while result_stall is high; the
// block keeps taking samples, and only a second batch end waits for it.
// Reset clears all estimator state; no result is pending after reset.
// ----------------------------------------------------------------------------
module baro_altitude_velocity_estimator
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              sample_valid,
    output logic              sample_stall,
    input  bave_pkg::sample_t sample,
    output logic              result_valid,
    input  logic              result_stall,
    output bave_pkg::result_t result
);
    import bave_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_LOOK, S_ALT, S_CHK, S_SGO, S_SDIV, S_UPD, S_MUL, S_STAMP, S_OUT
    } state_t;

    state_t                    state_reg;
    logic [IDX_W-1:0]          index_reg;
    logic signed [ALT_W-1:0]   prev_alt_reg;
    logic [TIME_W-1:0]         prev_time_reg;
    logic [MS_W-1:0]           liftoff_ms_reg;
    logic                      liftoff_seen_reg;
    logic signed [ALT_W-1:0]   cur_alt_reg;
    logic                      cur_alt_ok_reg;
    logic signed [SPEED_W-1:0] cur_speed_reg;
    logic                      cur_speed_ok_reg;
    logic [MS_W-1:0]           cur_ms_reg;
    logic                      result_valid_reg;
    result_t                   result_reg;
    logic [1:0]                mstep_reg;

    logic [PRESS_W-1:0]        press_reg;
    logic [PERIOD_W-1:0]       period_reg;
    logic [TIME_W-1:0]         start_reg;
    logic                      last_reg;
    logic signed [ALT_W-1:0]   node_a_reg;
    logic signed [43:0]        interp_reg;
    logic [TIME_W-1:0]         tprod_reg;
    logic [TIME_W-1:0]         t_reg;
    logic signed [45:0]        num_reg;
    logic [TIME_W-4:0]         msx_reg;
    logic [65:0]               macc_reg;

    logic [POS_W-1:0]          pos;
    logic [TAB_AW-1:0]         tab_idx;
    logic [PRESS_W-1:0]        tab_frac;
    logic signed [ALT_W:0]     node_diff;
    logic signed [ALT_W-1:0]   alt_new;
    logic signed [43:0]        interp_round;
    logic signed [ALT_W:0]     alt_diff;
    logic [TIME_W-1:0]         dt;
    logic [DIV_W-1:0]          num_mag;
    logic [DIV_W-1:0]          div_dividend;
    logic [DIV_W-1:0]          div_divisor;
    logic                      div_start;
    logic                      div_done;
    logic [DIV_W-1:0]          div_quo;
    logic signed [SPEED_W-1:0] speed_sat;
    logic [31:0]               mul_a;
    logic [31:0]               mul_b;
    logic [63:0]               mul_p;
    logic [65:0]               macc_next;
    logic [MS_W-1:0]           ms_quo;
    logic [MS_W-1:0]           ms_raised;
    logic                      out_free;

    // Table position and interpolation terms.
    always_comb
    begin
        pos       = POS_W'(press_reg) * POS_W'(ALT_TABLE_SIZE);
        tab_idx   = pos[POS_W-1:PRESS_W];
        if (tab_idx >= TAB_AW'(ALT_TABLE_SIZE)) begin
            tab_idx = TAB_AW'(ALT_TABLE_SIZE - 1);
        end
        tab_frac  = pos[PRESS_W-1:0];
        node_diff = (ALT_W+1)'(ALT_TABLE[tab_idx + 1'b1]) - (ALT_W+1)'(ALT_TABLE[tab_idx]);
        interp_round = interp_reg + 44'sd65536;
        alt_new   = node_a_reg + ALT_W'(interp_round >>> PRESS_W);
    end

    // Millisecond stamp: (t >> 3) times the reciprocal of 125, built from
    // four 32x32 partial products, keeping the product above bit 64.
    always_comb
    begin
        case (mstep_reg)
            2'd0:
            begin
                mul_a = msx_reg[31:0];
                mul_b = MS_RECIP[31:0];
            end
            2'd1:
            begin
                mul_a = msx_reg[31:0];
                mul_b = MS_RECIP[63:32];
            end
            2'd2:
            begin
                mul_a = {3'b000, msx_reg[TIME_W-4:32]};
                mul_b = MS_RECIP[31:0];
            end
            default:
            begin
                mul_a = {3'b000, msx_reg[TIME_W-4:32]};
                mul_b = MS_RECIP[63:32];
            end
        endcase
        mul_p = 64'(mul_a) * 64'(mul_b);
        case (mstep_reg)
            2'd0:    macc_next = 66'(mul_p);
            2'd2:    macc_next = macc_reg + 66'(mul_p);
            default: macc_next = (macc_reg >> 32) + 66'(mul_p);
        endcase
        ms_quo = macc_reg[MS_W+3:4];
    end

    // Speed terms, saturation and liftoff clamp.
    always_comb
    begin
        alt_diff = (ALT_W+1)'(cur_alt_reg) - (ALT_W+1)'(prev_alt_reg);
        dt       = t_reg - prev_time_reg;
        num_mag  = num_reg[45] ? DIV_W'(-num_reg) : DIV_W'(num_reg);
        if (num_reg[45]) begin
            speed_sat = (div_quo > 64'h8000_0000) ? 32'sh8000_0000
                                                  : SPEED_W'(-div_quo);
        end
        else begin
            speed_sat = (div_quo > 64'h7FFF_FFFF) ? 32'sh7FFF_FFFF
                                                  : SPEED_W'(div_quo);
        end
        ms_raised = (liftoff_seen_reg && (ms_quo < liftoff_ms_reg))
                    ? liftoff_ms_reg : ms_quo;
        out_free  = !result_valid_reg || !result_stall;
    end

    // Divider start and operands; only the speed quotient uses it.
    always_comb
    begin
        div_start    = (state_reg == S_SGO);
        div_dividend = num_mag;
        div_divisor  = dt;
    end

    bave_div u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_quo)
    );

    // Sequencer and estimator state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg        <= S_IDLE;
            index_reg        <= '0;
            prev_alt_reg     <= '0;
            prev_time_reg    <= '0;
            liftoff_ms_reg   <= '0;
            liftoff_seen_reg <= 1'b0;
            cur_alt_reg      <= '0;
            cur_alt_ok_reg   <= 1'b0;
            cur_speed_reg    <= '0;
            cur_speed_ok_reg <= 1'b0;
            cur_ms_reg       <= '0;
            result_valid_reg <= 1'b0;
            mstep_reg        <= '0;
        end
        else begin
            // A new beat replaces a taken one; a taken beat with none behind
            // it clears the valid flag.
            if ((state_reg == S_OUT) && out_free) begin
                result_valid_reg <= 1'b1;
            end
            else if (!result_stall) begin
                result_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (sample_valid) begin
                        if (sample.operation == OP_LIFTOFF) begin
                            liftoff_ms_reg   <= sample.liftoff_time_ms;
                            liftoff_seen_reg <= 1'b1;
                        end
                        else begin
                            state_reg <= S_LOOK;
                        end
                    end
                end
                S_LOOK:
                begin
                    state_reg <= S_ALT;
                end
                S_ALT:
                begin
                    cur_alt_reg    <= alt_new;
                    cur_alt_ok_reg <= 1'b1;
                    state_reg      <= S_CHK;
                end
                S_CHK:
                begin
                    if ((prev_time_reg != '0) && (t_reg > prev_time_reg)) begin
                        if (dt[TIME_W-1]) begin
                            cur_speed_reg    <= '0;
                            cur_speed_ok_reg <= 1'b1;
                            state_reg        <= S_UPD;
                        end
                        else begin
                            state_reg <= S_SGO;
                        end
                    end
                    else begin
                        state_reg <= S_UPD;
                    end
                end
                S_SGO:
                begin
                    state_reg <= S_SDIV;
                end
                S_SDIV:
                begin
                    if (div_done) begin
                        cur_speed_reg    <= speed_sat;
                        cur_speed_ok_reg <= 1'b1;
                        state_reg        <= S_UPD;
                    end
                end
                S_UPD:
                begin
                    prev_alt_reg  <= cur_alt_reg;
                    prev_time_reg <= t_reg;
                    if (last_reg) begin
                        index_reg <= '0;
                        mstep_reg <= '0;
                        state_reg <= S_MUL;
                    end
                    else begin
                        index_reg <= (index_reg == IDX_W'(MAX_BATCH - 1))
                                     ? '0 : index_reg + 1'b1;
                        state_reg <= S_IDLE;
                    end
                end
                S_MUL:
                begin
                    mstep_reg <= mstep_reg + 1'b1;
                    if (mstep_reg == 2'd3) begin
                        state_reg <= S_STAMP;
                    end
                end
                S_STAMP:
                begin
                    cur_ms_reg <= ms_raised;
                    state_reg  <= S_OUT;
                end
                S_OUT:
                begin
                    if (out_free) begin
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // Per-sample datapath registers.
    always_ff @(posedge clk)
    begin
        if ((state_reg == S_IDLE) && sample_valid && (sample.operation == OP_SAMPLE)) begin
            press_reg  <= (sample.baro_pa <= PRESS_W'(1)) ? SEA_LEVEL_PA
                                                         : sample.baro_pa;
            period_reg <= (sample.sample_period_us == '0) ? DEFAULT_PERIOD
                                                          : sample.sample_period_us;
            start_reg  <= sample.batch_start_us;
            last_reg   <= sample.last_in_batch;
        end
        if (state_reg == S_LOOK) begin
            node_a_reg <= ALT_TABLE[tab_idx];
            interp_reg <= 44'(node_diff * $signed({1'b0, tab_frac}));
            tprod_reg  <= TIME_W'(index_reg) * TIME_W'(period_reg);
        end
        if (state_reg == S_ALT) begin
            t_reg <= start_reg + tprod_reg;
        end
        if (state_reg == S_CHK) begin
            num_reg <= 46'(alt_diff * $signed({1'b0, US_PER_S}));
        end
        if (state_reg == S_UPD) begin
            msx_reg <= t_reg[TIME_W-1:3];
        end
        if (state_reg == S_MUL) begin
            macc_reg <= macc_next;
        end
        if ((state_reg == S_OUT) && out_free) begin
            result_reg.altitude_cm        <= cur_alt_reg;
            result_reg.altitude_ok        <= cur_alt_ok_reg;
            result_reg.vertical_speed_cms <= cur_speed_reg;
            result_reg.speed_ok           <= cur_speed_ok_reg;
            result_reg.update_time_ms     <= cur_ms_reg;
        end
    end

    assign sample_stall = (state_reg != S_IDLE);
    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule

@@ sim/baro_altitude_velocity_estimator_tb.sv @@
// ----------------------------------------------------------------------------
// Barometric altitude estimator testbench
// Drives batched pressure samples and liftoff events with random idling on
// both channels, and checks each batch-end beat against a local predictor.
// ----------------------------------------------------------------------------
module baro_altitude_velocity_estimator_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import bave_pkg::*;

    logic    clk;
    logic    rst_n;
    logic    sample_valid;
    logic    sample_stall;
    sample_t sample;
    logic    result_valid;
    logic    result_stall;
    result_t result;

    baro_altitude_velocity_estimator u_top
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_stall (sample_stall),
        .sample       (sample),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    // Clock with an 8 ns period.
    always
    begin
        clk = 1'b1;
        #4;
        clk = 1'b0;
        #4;
    end

    sample_t     pending_q [$];
    result_t     expected_q [$];
    int          errors = 0;
    bit          quiet = 1'b0;
    logic        sample_taken;
    int          send_idle = 0;
    int          recv_idle = 0;
    logic [23:0] node_cm [0:ALT_TABLE_SIZE];

    // Estimator state mirrored by the predictor.
    logic [9:0]         batch_pos;
    logic signed [23:0] last_alt;
    logic [63:0]        last_t;
    logic [31:0]        lift_ms;
    logic               lift_seen;
    logic signed [23:0] now_alt;
    logic               alt_ok;
    logic signed [31:0] speed;
    logic               speed_ok;
    logic [31:0]        stamp_ms;

    // Floor integer square root, digit by digit.
    function automatic longint unsigned int_sqrt(longint unsigned v);
        longint unsigned root;
        longint unsigned bitv;
        root = 0;
        bitv = 64'd1 << 62;
        while (bitv > v)
            bitv = bitv >> 2;
        while (bitv != 0)
        begin
            if (v >= root + bitv)
            begin
                v = v - (root + bitv);
                root = (root >> 1) + bitv;
            end
            else
            begin
                root = root >> 1;
            end
            bitv = bitv >> 2;
        end
        return root;
    endfunction

    // Fills the node table: Q30 log2, scaled by 0.1903, then 2^e.
    task automatic fill_nodes();
        longint unsigned root2 [0:30];
        longint unsigned ratio;
        longint unsigned y;
        longint unsigned eb;
        longint unsigned fp;
        longint          shift;
        longint          lg;
        longint          ex;
        longint          ip;
        root2[0] = 64'd1 << 31;
        for (int i = 1; i <= 30; i++)
            root2[i] = int_sqrt(root2[i-1] << 30);
        node_cm[0] = 24'd4433000;
        for (int k = 1; k <= ALT_TABLE_SIZE; k++)
        begin
            ratio = ((longint'(k) * 131072) << 30) / (longint'(ALT_TABLE_SIZE) * 101325);
            shift = 0;
            while (ratio < (64'd1 << 30))
            begin
                ratio = ratio << 1;
                shift--;
            end
            while (ratio >= (64'd1 << 31))
            begin
                ratio = ratio >> 1;
                shift++;
            end
            lg = shift * (longint'(1) << 30);
            for (int i = 1; i <= 30; i++)
            begin
                ratio = (ratio * ratio) >> 30;
                if (ratio >= (64'd1 << 31))
                begin
                    ratio = ratio >> 1;
                    lg = lg + (longint'(1) << (30 - i));
                end
            end
            ex = lg * 1903 / 10000;
            eb = ex + 64 * (longint'(1) << 30);
            ip = longint'(eb >> 30) - 64;
            fp = eb & ((64'd1 << 30) - 1);
            y = 64'd1 << 30;
            for (int i = 1; i <= 30; i++)
                if (fp[30-i])
                    y = (y * root2[i]) >> 30;
            if (ip < 0)
                y = (ip <= -63) ? 64'd0 : (y >> (-ip));
            else if (ip > 0)
                y = (ip >= 2) ? (y << 2) : (y << 1);
            node_cm[k] = 24'(64'd4433000 - ((64'd4433000 * y + (64'd1 << 29)) >> 30));
        end
    endtask

    // Interpolated altitude for one pressure, rounding half up.
    function automatic logic signed [23:0] altitude_of(logic [16:0] p);
        longint pos;
        longint idx;
        longint frac;
        longint lo;
        longint hi;
        pos  = longint'(p) * ALT_TABLE_SIZE;
        idx  = pos >>> 17;
        frac = pos & 131071;
        if (idx >= ALT_TABLE_SIZE)
            idx = ALT_TABLE_SIZE - 1;
        lo = longint'($signed(node_cm[idx]));
        hi = longint'($signed(node_cm[idx+1]));
        return 24'((lo * (131072 - frac) + hi * frac + 65536) >>> 17);
    endfunction

    // Applies one accepted beat and queues the batch-end result, if any.
    task automatic predict_estimate(sample_t s);
        logic [16:0] p;
        logic [31:0] per;
        logic [63:0] t;
        logic [63:0] dt;
        longint      num;
        longint      v;
        result_t     r;
        if (s.operation == OP_LIFTOFF)
        begin
            lift_ms   = s.liftoff_time_ms;
            lift_seen = 1'b1;
            return;
        end
        p   = (s.baro_pa <= 1) ? SEA_LEVEL_PA : s.baro_pa;
        per = (s.sample_period_us == 0) ? DEFAULT_PERIOD : s.sample_period_us;
        t   = s.batch_start_us + 64'(batch_pos) * 64'(per);
        now_alt = altitude_of(p);
        alt_ok  = 1'b1;
        if (last_t != 0 && t > last_t)
        begin
            dt  = t - last_t;
            num = (longint'(now_alt) - longint'(last_alt)) * 1000000;
            v   = dt[63] ? 0 : num / longint'(dt);
            if (v > 64'sd2147483647)
                v = 64'sd2147483647;
            if (v < -64'sd2147483648)
                v = -64'sd2147483648;
            speed    = 32'(v);
            speed_ok = 1'b1;
        end
        last_alt = now_alt;
        last_t   = t;
        stamp_ms = 32'(t / 64'd1000);
        if (!s.last_in_batch)
        begin
            batch_pos = batch_pos + 10'd1;
            return;
        end
        batch_pos = '0;
        if (lift_seen && stamp_ms < lift_ms)
            stamp_ms = lift_ms;
        r.altitude_cm        = now_alt;
        r.altitude_ok        = alt_ok;
        r.vertical_speed_cms = speed;
        r.speed_ok           = speed_ok;
        r.update_time_ms     = stamp_ms;
        expected_q.push_back(r);
    endtask

    function automatic sample_t pressure_beat(logic [16:0] p, logic [63:0] start,
                                              logic [31:0] per, logic last);
        sample_t s;
        s.operation        = OP_SAMPLE;
        s.baro_pa          = p;
        s.batch_start_us   = start;
        s.sample_period_us = per;
        s.last_in_batch    = last;
        s.liftoff_time_ms  = $urandom;
        return s;
    endfunction

    function automatic sample_t liftoff_beat(logic [31:0] ms);
        sample_t s;
        s.operation        = OP_LIFTOFF;
        s.baro_pa          = 17'($urandom);
        s.batch_start_us   = {$urandom, $urandom};
        s.sample_period_us = $urandom;
        s.last_in_batch    = 1'($urandom);
        s.liftoff_time_ms  = ms;
        return s;
    endfunction

    // Capture handshakes and check results at the rising edge.
    always @(posedge clk)
    begin
        result_t want;
        sample_taken <= rst_n && sample_valid && !sample_stall;
        if (rst_n && sample_valid && !sample_stall)
            predict_estimate(sample);
        if (rst_n && result_valid && !result_stall)
        begin
            if (expected_q.size() == 0)
            begin
                $error("unexpected result beat altitude_cm=%0d", result.altitude_cm);
                errors++;
            end
            else
            begin
                want = expected_q.pop_front();
                if (result.altitude_cm !== want.altitude_cm)
                begin
                    $error("altitude_cm: expected %0d, got %0d",
                           want.altitude_cm, result.altitude_cm);
                    errors++;
                end
                if (result.altitude_ok !== want.altitude_ok)
                begin
                    $error("altitude_ok: expected %0b, got %0b",
                           want.altitude_ok, result.altitude_ok);
                    errors++;
                end
                if (result.vertical_speed_cms !== want.vertical_speed_cms)
                begin
                    $error("vertical_speed_cms: expected %0d, got %0d",
                           want.vertical_speed_cms, result.vertical_speed_cms);
                    errors++;
                end
                if (result.speed_ok !== want.speed_ok)
                begin
                    $error("speed_ok: expected %0b, got %0b",
                           want.speed_ok, result.speed_ok);
                    errors++;
                end
                if (result.update_time_ms !== want.update_time_ms)
                begin
                    $error("update_time_ms: expected %0d, got %0d",
                           want.update_time_ms, result.update_time_ms);
                    errors++;
                end
            end
        end
    end

    // Sample driver: advances after each taken beat, idles in random bursts.
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (sample_taken)
                void'(pending_q.pop_front());
            if (!sample_valid || sample_taken)
            begin
                if (send_idle > 0)
                begin
                    send_idle--;
                    sample_valid <= 1'b0;
                end
                else if (pending_q.size() == 0)
                begin
                    sample_valid <= 1'b0;
                end
                else if (!quiet && $urandom_range(0, 7) == 0)
                begin
                    send_idle = $urandom_range(0, 8);
                    sample_valid <= 1'b0;
                end
                else
                begin
                    sample_valid <= 1'b1;
                    sample       <= pending_q[0];
                end
            end
            quiet <= (pending_q.size() < 150);
            // Result stall comes in bursts too.
            if (recv_idle > 0)
            begin
                recv_idle--;
                result_stall <= 1'b1;
            end
            else if (!quiet && $urandom_range(0, 5) == 0)
            begin
                recv_idle = $urandom_range(0, 8);
                result_stall <= 1'b1;
            end
            else
            begin
                result_stall <= 1'b0;
            end
        end
    end

    // Stimulus and end of run.
    initial
    begin
        int          count;
        int          nsamp;
        bit          long_done;
        logic [63:0] clock_us;
        logic [63:0] start;
        logic [31:0] per;
        logic [16:0] p;
        logic [16:0] level;

        sample_valid = 1'b0;
        result_stall = 1'b0;
        sample       = '0;
        sample_taken = 1'b0;
        rst_n        = 1'b0;
        batch_pos = '0;
        last_alt  = '0;
        last_t    = '0;
        lift_ms   = '0;
        lift_seen = 1'b0;
        now_alt   = '0;
        alt_ok    = 1'b0;
        speed     = '0;
        speed_ok  = 1'b0;
        stamp_ms  = '0;
        fill_nodes();

        // Directed part: low pressures, first sample with no prior time,
        // saturation both ways, a short batch, time going backward,
        // liftoff stamps, huge elapsed time and wrapped sample time.
        pending_q.push_back(pressure_beat(17'd0, 64'd0, 32'd0, 1'b1));
        pending_q.push_back(pressure_beat(17'd1, 64'd1000, 32'd0, 1'b1));
        pending_q.push_back(pressure_beat(17'd131071, 64'd2000, 32'd0, 1'b1));
        pending_q.push_back(pressure_beat(17'd2, 64'd2001, 32'd0, 1'b1));
        pending_q.push_back(pressure_beat(17'd131071, 64'd2002, 32'd5, 1'b1));
        pending_q.push_back(pressure_beat(17'd100000, 64'd10000, 32'd0, 1'b0));
        pending_q.push_back(pressure_beat(17'd99990, 64'd10000, 32'd0, 1'b0));
        pending_q.push_back(pressure_beat(17'd99980, 64'd10000, 32'd0, 1'b1));
        pending_q.push_back(pressure_beat(17'd90000, 64'd5000, 32'd20000, 1'b1));
        pending_q.push_back(liftoff_beat(32'hFFFF_FFFF));
        pending_q.push_back(pressure_beat(17'd95000, 64'd6000, 32'd0, 1'b1));
        pending_q.push_back(liftoff_beat(32'd0));
        pending_q.push_back(pressure_beat(17'd95001, 64'd7000, 32'hFFFF_FFFF, 1'b1));
        pending_q.push_back(pressure_beat(17'd60000, 64'h8000_0000_0000_2000, 32'd0, 1'b1));
        pending_q.push_back(pressure_beat(17'd101325, 64'd3000, 32'd0, 1'b1));
        pending_q.push_back(pressure_beat(17'd70000, 64'hFFFF_FFFF_FFFF_FFFF,
                                          32'hFFFF_FFFF, 1'b0));
        pending_q.push_back(pressure_beat(17'd70001, 64'hFFFF_FFFF_FFFF_FFFF,
                                          32'hFFFF_FFFF, 1'b1));
        pending_q.push_back(pressure_beat(17'd65536, 64'd4000, 32'd1, 1'b1));
        pending_q.push_back(pressure_beat(17'd512, 64'd4002, 32'd1, 1'b1));

        // Random part: mostly plausible flight batches on a running clock.
        count     = 0;
        long_done = 1'b0;
        clock_us  = 64'd100000;
        level     = 17'd101000;
        while (count < 1100)
        begin
            if ($urandom_range(0, 9) == 0)
            begin
                pending_q.push_back(liftoff_beat($urandom_range(0, 3) == 0 ? $urandom
                                    : 32'(clock_us / 1000) + $urandom_range(0, 5000)));
                count++;
                continue;
            end
            if ($urandom_range(0, 6) == 0)
            begin
                start = {$urandom, $urandom};
                per   = $urandom;
            end
            else
            begin
                start = clock_us + $urandom_range(0, 2000);
                per   = ($urandom_range(0, 2) == 0) ? 32'd0 : $urandom_range(1, 20000);
            end
            nsamp = $urandom_range(1, 6);
            if (!long_done && count > 50)
            begin
                nsamp     = 1030;
                per       = 32'd0;
                long_done = 1'b1;
            end
            for (int i = 0; i < nsamp; i++)
            begin
                case ($urandom_range(0, 9))
                    0:       p = 17'($urandom_range(0, 1));
                    1, 2:    p = 17'($urandom);
                    default:
                    begin
                        level = 17'(int'(level) + $urandom_range(0, 800) - 400);
                        if (level > 17'd103000 || level < 17'd20000)
                            level = 17'd101000;
                        p = level;
                    end
                endcase
                pending_q.push_back(pressure_beat(p, start, per, i == nsamp - 1));
                count++;
            end
            clock_us = clock_us + 64'(nsamp) * 64'((per == 0) ? 1000 : per % 50000)
                       + $urandom_range(1, 30000);
        end

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        wait (pending_q.size() == 0 && !sample_valid);
        wait (expected_q.size() == 0);
        repeat (300) @(posedge clk);
        if (errors == 0 && expected_q.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    // Watchdog.
    initial
    begin
        #20ms;
        $display("tb: failure");
        $finish;
    end

endmodule

@@ filelist.f @@
src/bave_pkg.sv
src/bave_div.sv
src/baro_altitude_velocity_estimator.sv
sim/baro_altitude_velocity_estimator_tb.sv
